FILE: rtl/cle_pkg.sv
// cle_pkg: shared constants, codes and types of the contiguous list engine.
// Used by cle_ctrl, cle_dpath and contiguous_list_engine; depends on nothing.
`timescale 1ns / 1ps

package cle_pkg;

    // Default store depth (entries of 32 bits)
    localparam int DEPTH_DEF = 256;

    // Field widths
    localparam int CMD_W  = 3;
    localparam int POS_W  = 9;
    localparam int VAL_W  = 32;
    localparam int IDX_W  = 9;
    localparam int CNT_W  = 9;
    localparam int CAP_W  = 9;
    localparam int STAT_W = 2;
    localparam int GS_W   = 9;

    // Command codes; 5..7 do nothing
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_POS  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

    localparam logic [IDX_W-1:0] NOT_FOUND = 9'h1FF;
    localparam logic [GS_W-1:0]  GS_RESET  = 9'd4;
    localparam logic [CAP_W-1:0] CAP_MAX   = 9'd511;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_DEL_RD,
        S_DEL_WR,
        S_DEL_FIN,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_DONE
    } cle_state_t;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_COUNT,
        PTR_POS,
        PTR_ZERO,
        PTR_INC,
        PTR_DEC
    } cle_ptr_op_t;

    typedef enum logic [1:0] {
        RA_POS,
        RA_PTR,
        RA_PTR_M1,
        RA_PTR_P1
    } cle_raddr_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_POS_VAL,
        WR_PTR_RDATA
    } cle_wr_t;

    // Controller -> datapath
    typedef struct packed {
        logic        load_item;
        logic        rd_en;
        cle_raddr_t  rd_sel;
        cle_wr_t     wr_sel;
        cle_ptr_op_t ptr_op;
        logic        set_status;
        logic        set_rd;
        logic        set_found;
        logic        cnt_inc;
        logic        cnt_dec;
        logic        cap_grow;
        logic        out_load;
    } cle_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             pos_bad;
        logic             full;
        logic             cnt_eq_pos;
        logic             pos_p1_lt_cnt;
        logic             cnt_zero;
        logic             ptr_m1_eq_pos;
        logic             ptr_p1_lt_cnt;
        logic             ptr_p2_lt_cnt;
        logic             match;
        logic             out_busy;
    } cle_stat_t;

endpackage

FILE: rtl/cle_ctrl.sv
// cle_ctrl: sequencer of the list engine (decode, shift loops, search loop).
// Depends on cle_pkg; drives cle_dpath through cle_cmd_t.
`timescale 1ns / 1ps

module cle_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  cle_pkg::cle_stat_t  stat,
    output cle_pkg::cle_cmd_t   cmd
);

    cle_pkg::cle_state_t state_reg;
    cle_pkg::cle_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cle_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cle_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = cle_pkg::S_DECODE;
                end
            end
            cle_pkg::S_DECODE:
            begin
                state_next = cle_pkg::S_DONE;
                case (stat.cmd)
                    cle_pkg::CMD_READ:
                    begin
                        if (!stat.pos_bad)
                        begin
                            state_next = cle_pkg::S_READ;
                        end
                    end
                    cle_pkg::CMD_INSERT:
                    begin
                        if (!stat.pos_bad && !stat.full)
                        begin
                            state_next = stat.cnt_eq_pos ? cle_pkg::S_INS_PUT
                                                         : cle_pkg::S_INS_RD;
                        end
                    end
                    cle_pkg::CMD_DELETE:
                    begin
                        if (!stat.pos_bad)
                        begin
                            state_next = stat.pos_p1_lt_cnt ? cle_pkg::S_DEL_RD
                                                            : cle_pkg::S_DEL_FIN;
                        end
                    end
                    cle_pkg::CMD_SEARCH:
                    begin
                        if (!stat.cnt_zero)
                        begin
                            state_next = cle_pkg::S_SRCH_RD;
                        end
                    end
                    default:
                    begin
                        state_next = cle_pkg::S_DONE;
                    end
                endcase
            end
            cle_pkg::S_READ:
            begin
                state_next = cle_pkg::S_DONE;
            end
            cle_pkg::S_INS_RD:
            begin
                state_next = cle_pkg::S_INS_WR;
            end
            cle_pkg::S_INS_WR:
            begin
                state_next = stat.ptr_m1_eq_pos ? cle_pkg::S_INS_PUT : cle_pkg::S_INS_RD;
            end
            cle_pkg::S_INS_PUT:
            begin
                state_next = cle_pkg::S_DONE;
            end
            cle_pkg::S_DEL_RD:
            begin
                state_next = cle_pkg::S_DEL_WR;
            end
            cle_pkg::S_DEL_WR:
            begin
                state_next = stat.ptr_p2_lt_cnt ? cle_pkg::S_DEL_RD : cle_pkg::S_DEL_FIN;
            end
            cle_pkg::S_DEL_FIN:
            begin
                state_next = cle_pkg::S_DONE;
            end
            cle_pkg::S_SRCH_RD:
            begin
                state_next = cle_pkg::S_SRCH_CMP;
            end
            cle_pkg::S_SRCH_CMP:
            begin
                if (stat.match || !stat.ptr_p1_lt_cnt)
                begin
                    state_next = cle_pkg::S_DONE;
                end
                else
                begin
                    state_next = cle_pkg::S_SRCH_RD;
                end
            end
            cle_pkg::S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    state_next = cle_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cle_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            cle_pkg::S_IDLE:
            begin
                s_tready      = 1'b1;
                cmd.load_item = s_tvalid;
            end
            cle_pkg::S_DECODE:
            begin
                cmd.set_status = 1'b1;
                case (stat.cmd)
                    cle_pkg::CMD_READ:
                    begin
                        cmd.rd_en  = !stat.pos_bad;
                        cmd.rd_sel = cle_pkg::RA_POS;
                    end
                    cle_pkg::CMD_WRITE:
                    begin
                        if (!stat.pos_bad)
                        begin
                            cmd.wr_sel = cle_pkg::WR_POS_VAL;
                        end
                    end
                    cle_pkg::CMD_INSERT:
                    begin
                        if (!stat.pos_bad && !stat.full)
                        begin
                            cmd.cap_grow = 1'b1;
                            cmd.ptr_op   = cle_pkg::PTR_COUNT;
                        end
                    end
                    cle_pkg::CMD_DELETE:
                    begin
                        cmd.ptr_op = cle_pkg::PTR_POS;
                    end
                    cle_pkg::CMD_SEARCH:
                    begin
                        cmd.ptr_op = cle_pkg::PTR_ZERO;
                    end
                    default:
                    begin
                        cmd.ptr_op = cle_pkg::PTR_HOLD;
                    end
                endcase
            end
            cle_pkg::S_READ:
            begin
                cmd.set_rd = 1'b1;
            end
            cle_pkg::S_INS_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = cle_pkg::RA_PTR_M1;
            end
            cle_pkg::S_INS_WR:
            begin
                cmd.wr_sel = cle_pkg::WR_PTR_RDATA;
                cmd.ptr_op = cle_pkg::PTR_DEC;
            end
            cle_pkg::S_INS_PUT:
            begin
                cmd.wr_sel  = cle_pkg::WR_POS_VAL;
                cmd.cnt_inc = 1'b1;
            end
            cle_pkg::S_DEL_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = cle_pkg::RA_PTR_P1;
            end
            cle_pkg::S_DEL_WR:
            begin
                cmd.wr_sel = cle_pkg::WR_PTR_RDATA;
                cmd.ptr_op = cle_pkg::PTR_INC;
            end
            cle_pkg::S_DEL_FIN:
            begin
                cmd.cnt_dec = 1'b1;
            end
            cle_pkg::S_SRCH_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = cle_pkg::RA_PTR;
            end
            cle_pkg::S_SRCH_CMP:
            begin
                if (stat.match)
                begin
                    cmd.set_found = 1'b1;
                end
                else if (stat.ptr_p1_lt_cnt)
                begin
                    cmd.ptr_op = cle_pkg::PTR_INC;
                end
            end
            cle_pkg::S_DONE:
            begin
                cmd.out_load = !stat.out_busy;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/cle_dpath.sv
// cle_dpath: entry store, count, capacity, walk pointer and result register.
// Depends on cle_pkg; steered by cle_ctrl through cle_cmd_t.
`timescale 1ns / 1ps

module cle_dpath
#(
    parameter int DEPTH = cle_pkg::DEPTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cle_pkg::GS_W-1:0]          cfg_data,
    input  logic [cle_pkg::CMD_W-1:0]         in_cmd,
    input  logic [cle_pkg::POS_W-1:0]         in_pos,
    input  logic [cle_pkg::VAL_W-1:0]         in_val,
    input  cle_pkg::cle_cmd_t                 cmd,
    output cle_pkg::cle_stat_t                stat,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [cle_pkg::VAL_W-1:0]         out_rd,
    output logic [cle_pkg::IDX_W-1:0]         out_found,
    output logic [cle_pkg::CNT_W-1:0]         out_cnt,
    output logic [cle_pkg::CAP_W-1:0]         out_cap,
    output logic [cle_pkg::STAT_W-1:0]        out_status
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = ((CW > cle_pkg::POS_W) ? CW : cle_pkg::POS_W) + 1;
    localparam int SW   = CMPW + 1;

    logic [cle_pkg::VAL_W-1:0] mem [DEPTH];

    logic [cle_pkg::CMD_W-1:0]  cmd_reg;
    logic [cle_pkg::POS_W-1:0]  pos_reg;
    logic [cle_pkg::VAL_W-1:0]  val_reg;
    logic [cle_pkg::GS_W-1:0]   gs_reg;
    logic [CW-1:0]              cnt_reg;
    logic [CW-1:0]              cnt_next;
    logic [cle_pkg::CAP_W-1:0]  cap_reg;
    logic [cle_pkg::CAP_W-1:0]  cap_next;
    logic [CW-1:0]              ptr_reg;
    logic [CW-1:0]              ptr_next;
    logic [cle_pkg::VAL_W-1:0]  rdata_reg;
    logic [cle_pkg::VAL_W-1:0]  res_rd_reg;
    logic [cle_pkg::IDX_W-1:0]  res_found_reg;
    logic [cle_pkg::STAT_W-1:0] res_status_reg;
    logic                       out_valid_reg;
    logic [cle_pkg::VAL_W-1:0]  out_rd_reg;
    logic [cle_pkg::IDX_W-1:0]  out_found_reg;
    logic [cle_pkg::CNT_W-1:0]  out_cnt_reg;
    logic [cle_pkg::CAP_W-1:0]  out_cap_reg;
    logic [cle_pkg::STAT_W-1:0] out_status_reg;

    logic [CMPW-1:0] pos_ext;
    logic [CMPW-1:0] cnt_ext;
    logic [CMPW-1:0] ptr_ext;
    logic [CMPW-1:0] cap_ext;
    logic [CMPW-1:0] ptr_m1;
    logic [CMPW-1:0] ptr_p1;
    logic [CMPW-1:0] cnt_dec_ext;
    logic [cle_pkg::CAP_W:0] cap_sum;
    logic [SW-1:0]   slack;
    logic [SW-1:0]   twice_gs;
    logic            pos_chk_ge;
    logic            pos_chk_gt;
    logic [cle_pkg::STAT_W-1:0] status_calc;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [cle_pkg::VAL_W-1:0] wr_data;
    logic [AW-1:0]   rd_addr;

    assign pos_ext     = CMPW'(pos_reg);
    assign cnt_ext     = CMPW'(cnt_reg);
    assign ptr_ext     = CMPW'(ptr_reg);
    assign cap_ext     = CMPW'(cap_reg);
    assign ptr_m1      = ptr_ext - CMPW'(1);
    assign ptr_p1      = ptr_ext + CMPW'(1);
    assign cnt_dec_ext = cnt_ext - CMPW'(1);

    // position checks; bad position wins over full store
    assign pos_chk_ge = (pos_ext >= cnt_ext);
    assign pos_chk_gt = (pos_ext > cnt_ext);

    always_comb
    begin
        stat.cmd = cmd_reg;
        case (cmd_reg)
            cle_pkg::CMD_READ,
            cle_pkg::CMD_WRITE,
            cle_pkg::CMD_DELETE: stat.pos_bad = pos_chk_ge;
            cle_pkg::CMD_INSERT: stat.pos_bad = pos_chk_gt;
            default:             stat.pos_bad = 1'b0;
        endcase
        stat.full          = (cmd_reg == cle_pkg::CMD_INSERT) && (cnt_ext == CMPW'(DEPTH));
        stat.cnt_eq_pos    = (cnt_ext == pos_ext);
        stat.pos_p1_lt_cnt = ((pos_ext + CMPW'(1)) < cnt_ext);
        stat.cnt_zero      = (cnt_ext == '0);
        stat.ptr_m1_eq_pos = (ptr_m1 == pos_ext);
        stat.ptr_p1_lt_cnt = (ptr_p1 < cnt_ext);
        stat.ptr_p2_lt_cnt = ((ptr_ext + CMPW'(2)) < cnt_ext);
        stat.match         = (rdata_reg == val_reg);
        stat.out_busy      = out_valid_reg && !out_ready;
    end

    always_comb
    begin
        if (stat.pos_bad)
        begin
            status_calc = cle_pkg::STAT_POS;
        end
        else if (stat.full)
        begin
            status_calc = cle_pkg::STAT_FULL;
        end
        else
        begin
            status_calc = cle_pkg::STAT_OK;
        end
    end

    // store ports
    always_comb
    begin
        case (cmd.rd_sel)
            cle_pkg::RA_POS:    rd_addr = pos_ext[AW-1:0];
            cle_pkg::RA_PTR:    rd_addr = ptr_ext[AW-1:0];
            cle_pkg::RA_PTR_M1: rd_addr = ptr_m1[AW-1:0];
            cle_pkg::RA_PTR_P1: rd_addr = ptr_p1[AW-1:0];
            default:            rd_addr = ptr_ext[AW-1:0];
        endcase
        case (cmd.wr_sel)
            cle_pkg::WR_POS_VAL:
            begin
                wr_en   = 1'b1;
                wr_addr = pos_ext[AW-1:0];
                wr_data = val_reg;
            end
            cle_pkg::WR_PTR_RDATA:
            begin
                wr_en   = 1'b1;
                wr_addr = ptr_ext[AW-1:0];
                wr_data = rdata_reg;
            end
            default:
            begin
                wr_en   = 1'b0;
                wr_addr = ptr_ext[AW-1:0];
                wr_data = rdata_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // walk pointer
    always_comb
    begin
        case (cmd.ptr_op)
            cle_pkg::PTR_COUNT: ptr_next = cnt_reg;
            cle_pkg::PTR_POS:   ptr_next = pos_ext[CW-1:0];
            cle_pkg::PTR_ZERO:  ptr_next = '0;
            cle_pkg::PTR_INC:   ptr_next = ptr_p1[CW-1:0];
            cle_pkg::PTR_DEC:   ptr_next = ptr_m1[CW-1:0];
            default:            ptr_next = ptr_reg;
        endcase
    end

    // count and capacity bookkeeping
    assign cap_sum  = {1'b0, cap_reg} + {1'b0, gs_reg};
    assign slack    = SW'(cap_ext) - SW'(cnt_dec_ext);
    assign twice_gs = SW'({gs_reg, 1'b0});

    always_comb
    begin
        cnt_next = cnt_reg;
        cap_next = cap_reg;
        if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            cnt_next = cnt_dec_ext[CW-1:0];
            if (slack == twice_gs)
            begin
                cap_next = cap_reg - gs_reg;
            end
        end
        if (cmd.cap_grow && (cnt_ext == cap_ext))
        begin
            cap_next = cap_sum[cle_pkg::CAP_W] ? cle_pkg::CAP_MAX : cap_sum[cle_pkg::CAP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gs_reg        <= cle_pkg::GS_RESET;
            cnt_reg       <= '0;
            cap_reg       <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                gs_reg <= cfg_data;
            end
            cnt_reg <= cnt_next;
            cap_reg <= cap_next;
            ptr_reg <= ptr_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            cmd_reg        <= in_cmd;
            pos_reg        <= in_pos;
            val_reg        <= in_val;
            res_rd_reg     <= '0;
            res_found_reg  <= cle_pkg::NOT_FOUND;
            res_status_reg <= cle_pkg::STAT_OK;
        end
        if (cmd.set_status)
        begin
            res_status_reg <= status_calc;
        end
        if (cmd.set_rd)
        begin
            res_rd_reg <= rdata_reg;
        end
        if (cmd.set_found)
        begin
            res_found_reg <= ptr_ext[cle_pkg::IDX_W-1:0];
        end
        if (cmd.out_load)
        begin
            out_rd_reg     <= res_rd_reg;
            out_found_reg  <= res_found_reg;
            out_cnt_reg    <= cnt_ext[cle_pkg::CNT_W-1:0];
            out_cap_reg    <= cap_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_rd     = out_rd_reg;
    assign out_found  = out_found_reg;
    assign out_cnt    = out_cnt_reg;
    assign out_cap    = out_cap_reg;
    assign out_status = out_status_reg;

endmodule

FILE: rtl/contiguous_list_engine.sv
// contiguous_list_engine: top level joining cle_ctrl and cle_dpath; depends on cle_pkg.
// Insert and delete shift the entries from pos on, one at a time; search walks up from index 0
// to a hit or the end of the list (an empty list is not walked); read, write and errors take no loop.
// One item at a time; each shifted or searched entry is a read, then a write or compare,
// on the single registered read port; a new item is taken while a result beat waits.
// rst_n (async, active low) clears count and capacity, sets growth_step to 4; store not cleared.
`timescale 1ns / 1ps

module contiguous_list_engine
#(
    parameter int DEPTH = cle_pkg::DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration: growth_step
    input  logic        cfg_we,
    input  logic [8:0]  cfg_data,
    // command beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [8:0] position, [40:9] data_value, [47:41] zero
    input  logic [2:0]  s_tuser,   // [2:0] command
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] read_value, [40:32] found_index,
                                   // [49:41] entry_count, [58:50] capacity_figure, [63:59] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    cle_pkg::cle_cmd_t  cmd;
    cle_pkg::cle_stat_t stat;

    logic [cle_pkg::VAL_W-1:0]  read_value;
    logic [cle_pkg::IDX_W-1:0]  found_index;
    logic [cle_pkg::CNT_W-1:0]  entry_count;
    logic [cle_pkg::CAP_W-1:0]  capacity_figure;
    logic [cle_pkg::STAT_W-1:0] status;

    // Sequencer: decodes the held command and walks the shift or search loop.
    cle_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: entry store, count/capacity, pointer and result register.
    cle_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .in_cmd     (s_tuser),
        .in_pos     (s_tdata[8:0]),
        .in_val     (s_tdata[40:9]),
        .cmd        (cmd),
        .stat       (stat),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_rd     (read_value),
        .out_found  (found_index),
        .out_cnt    (entry_count),
        .out_cap    (capacity_figure),
        .out_status (status)
    );

    // Pack result fields, lowest first.
    assign m_tdata = {5'd0, capacity_figure, entry_count, found_index, read_value};
    assign m_tuser = status;

    // Result register is only reloaded when it is empty or being drained.
    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(m_tvalid && !m_tready))
        else $error("result overwritten while still pending");

    // A full-store error can only be reported with the list at full depth.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == cle_pkg::STAT_FULL))
            |-> (m_tdata[49:41] == DEPTH[8:0]))
        else $error("store full reported below depth");

    // A hit index only comes from a successful search, which reads nothing.
    a_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[40:32] != cle_pkg::NOT_FOUND))
            |-> ((m_tuser == cle_pkg::STAT_OK) && (m_tdata[31:0] == '0)))
        else $error("found index with error or read data");

endmodule

FILE: bench/contiguous_list_engine_tb.sv
// Self-checking bench for contiguous_list_engine: directed table, then random command phases
// over several growth_step settings, each result beat checked against a row or list predictor.
// Depends on cle_pkg and the contiguous_list_engine RTL only.
`timescale 1ns / 1ps

module contiguous_list_engine_tb;

    localparam logic [cle_pkg::CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [cle_pkg::CMD_W-1:0] CMD_UNUSED_HI = 3'd7;
    localparam logic [cle_pkg::VAL_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [cle_pkg::VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [cle_pkg::VAL_W-1:0] VAL_ONES = 32'hFFFF_FFFF;
    localparam int TAIL_CYCLES = 40;
    localparam int REPORT_MAX = 10;
    // random command mix, besides insert and delete
    localparam int W_READ = 12;
    localparam int W_WRITE = 10;
    localparam int W_SEARCH = 16;

    typedef struct packed {
        logic [cle_pkg::VAL_W-1:0]  rd;
        logic [cle_pkg::IDX_W-1:0]  idx;
        logic [cle_pkg::CNT_W-1:0]  cnt;
        logic [cle_pkg::CAP_W-1:0]  cap;
        logic [cle_pkg::STAT_W-1:0] stat;
    } list_result_t;

    typedef struct packed {
        logic [cle_pkg::CMD_W-1:0] cmd;
        logic [cle_pkg::POS_W-1:0] pos;
        logic [cle_pkg::VAL_W-1:0] val;
        logic                      typed;
        list_result_t              want;
    } dir_row_t;

    localparam list_result_t NO_TYPED = '0;
    localparam int DIR_ROWS = 25;

    // empty list, then a small list built from the data extremes, then emptied again
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        '{cle_pkg::CMD_READ, 9'd0, 32'd0, 1'b1,
          '{32'd0, cle_pkg::NOT_FOUND, 9'd0, 9'd0, cle_pkg::STAT_POS}},
        '{cle_pkg::CMD_WRITE, 9'd0, 32'd5, 1'b1,
          '{32'd0, cle_pkg::NOT_FOUND, 9'd0, 9'd0, cle_pkg::STAT_POS}},
        '{cle_pkg::CMD_DELETE, 9'd0, 32'd0, 1'b1,
          '{32'd0, cle_pkg::NOT_FOUND, 9'd0, 9'd0, cle_pkg::STAT_POS}},
        '{cle_pkg::CMD_SEARCH, 9'd0, 32'd0, 1'b1,
          '{32'd0, cle_pkg::NOT_FOUND, 9'd0, 9'd0, cle_pkg::STAT_OK}},
        '{cle_pkg::CMD_INSERT, 9'd1, 32'd9, 1'b1,
          '{32'd0, cle_pkg::NOT_FOUND, 9'd0, 9'd0, cle_pkg::STAT_POS}},
        '{cle_pkg::CMD_INSERT, 9'd0, VAL_MIN, 1'b1,
          '{32'd0, cle_pkg::NOT_FOUND, 9'd1, 9'd4, cle_pkg::STAT_OK}},
        '{cle_pkg::CMD_INSERT, 9'd1, VAL_MAX, 1'b1,
          '{32'd0, cle_pkg::NOT_FOUND, 9'd2, 9'd4, cle_pkg::STAT_OK}},
        '{cle_pkg::CMD_INSERT, 9'd0, VAL_ONES, 1'b1,
          '{32'd0, cle_pkg::NOT_FOUND, 9'd3, 9'd4, cle_pkg::STAT_OK}},
        '{cle_pkg::CMD_READ, 9'd2, 32'd0, 1'b1,
          '{VAL_MAX, cle_pkg::NOT_FOUND, 9'd3, 9'd4, cle_pkg::STAT_OK}},
        '{cle_pkg::CMD_READ, 9'd0, 32'd0, 1'b1,
          '{VAL_ONES, cle_pkg::NOT_FOUND, 9'd3, 9'd4, cle_pkg::STAT_OK}},
        '{cle_pkg::CMD_SEARCH, 9'd0, VAL_MIN, 1'b1,
          '{32'd0, 9'd1, 9'd3, 9'd4, cle_pkg::STAT_OK}},
        '{cle_pkg::CMD_SEARCH, 9'd0, 32'h1234_5678, 1'b1,
          '{32'd0, cle_pkg::NOT_FOUND, 9'd3, 9'd4, cle_pkg::STAT_OK}},
        '{cle_pkg::CMD_WRITE, 9'd1, 32'd0, 1'b1,
          '{32'd0, cle_pkg::NOT_FOUND, 9'd3, 9'd4, cle_pkg::STAT_OK}},
        '{cle_pkg::CMD_INSERT, 9'd3, 32'd0, 1'b1,
          '{32'd0, cle_pkg::NOT_FOUND, 9'd4, 9'd4, cle_pkg::STAT_OK}},
        '{cle_pkg::CMD_SEARCH, 9'd0, 32'd0, 1'b1,
          '{32'd0, 9'd1, 9'd4, 9'd4, cle_pkg::STAT_OK}},
        '{cle_pkg::CMD_INSERT, 9'd4, 32'd1, 1'b1,
          '{32'd0, cle_pkg::NOT_FOUND, 9'd5, 9'd8, cle_pkg::STAT_OK}},
        '{cle_pkg::CMD_INSERT, 9'd511, 32'hAAAA_AAAA, 1'b1,
          '{32'd0, cle_pkg::NOT_FOUND, 9'd5, 9'd8, cle_pkg::STAT_POS}},
        '{cle_pkg::CMD_READ, 9'd256, 32'd0, 1'b1,
          '{32'd0, cle_pkg::NOT_FOUND, 9'd5, 9'd8, cle_pkg::STAT_POS}},
        '{CMD_UNUSED_LO, 9'd0, 32'd0, 1'b1,
          '{32'd0, cle_pkg::NOT_FOUND, 9'd5, 9'd8, cle_pkg::STAT_OK}},
        '{CMD_UNUSED_HI, 9'd511, VAL_ONES, 1'b1,
          '{32'd0, cle_pkg::NOT_FOUND, 9'd5, 9'd8, cle_pkg::STAT_OK}},
        '{cle_pkg::CMD_DELETE, 9'd0, 32'd0, 1'b0, NO_TYPED},
        '{cle_pkg::CMD_DELETE, 9'd3, 32'd0, 1'b0, NO_TYPED},
        '{cle_pkg::CMD_DELETE, 9'd0, 32'd0, 1'b0, NO_TYPED},
        '{cle_pkg::CMD_DELETE, 9'd1, 32'd0, 1'b0, NO_TYPED},
        '{cle_pkg::CMD_DELETE, 9'd0, 32'd0, 1'b1,
          '{32'd0, cle_pkg::NOT_FOUND, 9'd0, 9'd4, cle_pkg::STAT_OK}}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [8:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;

    // predictor state
    logic [cle_pkg::VAL_W-1:0] shadow_list [cle_pkg::DEPTH_DEF];
    int                        list_len = 0;
    int                        cap_fig = 0;
    logic [cle_pkg::GS_W-1:0]  step_cfg = cle_pkg::GS_RESET;

    list_result_t pending_results [$];
    int           mismatch_cnt = 0;
    bit           ready_idle_en = 1'b0;
    int           stall_left = 0;

    contiguous_list_engine #(.DEPTH(cle_pkg::DEPTH_DEF)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    initial
    begin
        #100ms;
        $display("Regression FAIL");
        $finish;
    end

    // applies one command to the shadow list and returns the result it should give
    task automatic list_apply(input logic [cle_pkg::CMD_W-1:0] cmd,
                              input logic [cle_pkg::POS_W-1:0] pos,
                              input logic [cle_pkg::VAL_W-1:0] val, output list_result_t res);
        int p;
        int i;
        p = int'(pos);
        res.rd = '0;
        res.idx = cle_pkg::NOT_FOUND;
        res.stat = cle_pkg::STAT_OK;
        case (cmd)
            cle_pkg::CMD_READ:
            begin
                if (p >= list_len)
                    res.stat = cle_pkg::STAT_POS;
                else
                    res.rd = shadow_list[p];
            end
            cle_pkg::CMD_WRITE:
            begin
                if (p >= list_len)
                    res.stat = cle_pkg::STAT_POS;
                else
                    shadow_list[p] = val;
            end
            cle_pkg::CMD_INSERT:
            begin
                if (p > list_len)
                    res.stat = cle_pkg::STAT_POS;
                else if (list_len >= cle_pkg::DEPTH_DEF)
                    res.stat = cle_pkg::STAT_FULL;
                else
                begin
                    if (list_len == cap_fig)
                        cap_fig = (cap_fig + int'(step_cfg) > int'(cle_pkg::CAP_MAX)) ?
                                  int'(cle_pkg::CAP_MAX) : cap_fig + int'(step_cfg);
                    for (i = list_len; i > p; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[p] = val;
                    list_len++;
                end
            end
            cle_pkg::CMD_DELETE:
            begin
                if (p >= list_len)
                    res.stat = cle_pkg::STAT_POS;
                else
                begin
                    for (i = p; i + 1 < list_len; i++)
                        shadow_list[i] = shadow_list[i+1];
                    list_len--;
                    if (cap_fig - list_len == 2 * int'(step_cfg))
                        cap_fig -= int'(step_cfg);
                end
            end
            cle_pkg::CMD_SEARCH:
            begin
                for (i = 0; i < list_len; i++)
                begin
                    if (shadow_list[i] == val)
                    begin
                        res.idx = 9'(i);
                        break;
                    end
                end
            end
            default:
                ;
        endcase
        res.cnt = 9'(list_len);
        res.cap = 9'(cap_fig);
    endtask

    function automatic logic [cle_pkg::VAL_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return '0;
            3: return VAL_ONES;
            4, 5, 6: return 32'($urandom_range(0, 7));   // small pool: duplicates, search hits
            default: return $urandom;
        endcase
    endfunction

    // sends one command beat and books its expected result at the accepting edge
    task automatic issue(input logic [cle_pkg::CMD_W-1:0] cmd,
                         input logic [cle_pkg::POS_W-1:0] pos,
                         input logic [cle_pkg::VAL_W-1:0] val, input int gap,
                         input bit typed, input list_result_t typed_res);
        list_result_t res;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, val, pos};
        s_tuser <= cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        list_apply(cmd, pos, val, res);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic set_step(input logic [cle_pkg::GS_W-1:0] step);
        cfg_we <= 1'b1;
        cfg_data <= step;
        @(posedge clk);
        cfg_we <= 1'b0;
        step_cfg = step;
    endtask

    // mostly well-formed commands steering the list toward target; some noise
    task automatic pick_item(input int target, input bit heavy,
                             output logic [cle_pkg::CMD_W-1:0] cmd,
                             output logic [cle_pkg::POS_W-1:0] pos,
                             output logic [cle_pkg::VAL_W-1:0] val);
        int r;
        int w_ins;
        int w_del;
        val = rand_word();
        pos = 9'($urandom);
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
            return;
        end
        if (r < 7)
        begin
            cmd = 3'($urandom_range(cle_pkg::CMD_READ, cle_pkg::CMD_SEARCH));
            return;
        end
        if (list_len < target)
        begin
            w_ins = heavy ? 120 : 40;
            w_del = heavy ? 5 : 15;
        end
        else
        begin
            w_ins = 15;
            w_del = 40;
        end
        r = $urandom_range(0, w_ins + w_del + W_READ + W_WRITE + W_SEARCH - 1);
        if (r < w_ins)
            cmd = cle_pkg::CMD_INSERT;
        else if (r < w_ins + w_del)
            cmd = cle_pkg::CMD_DELETE;
        else if (r < w_ins + w_del + W_READ)
            cmd = cle_pkg::CMD_READ;
        else if (r < w_ins + w_del + W_READ + W_WRITE)
            cmd = cle_pkg::CMD_WRITE;
        else
            cmd = cle_pkg::CMD_SEARCH;
        if (list_len == 0 && cmd != cle_pkg::CMD_SEARCH)
            cmd = cle_pkg::CMD_INSERT;
        case (cmd)
            cle_pkg::CMD_INSERT:
                pos = 9'($urandom_range(0, list_len));
            cle_pkg::CMD_SEARCH:
            begin
                if (list_len > 0 && $urandom_range(0, 9) < 6)
                    val = shadow_list[$urandom_range(0, list_len - 1)];
            end
            default:
                pos = 9'($urandom_range(0, list_len - 1));
        endcase
    endtask

    task automatic run_phase(input logic [cle_pkg::GS_W-1:0] step, input int n_items,
                             input int target, input bit heavy, input bit idle);
        logic [cle_pkg::CMD_W-1:0] cmd;
        logic [cle_pkg::POS_W-1:0] pos;
        logic [cle_pkg::VAL_W-1:0] val;
        int                        gap;
        wait_drained();
        set_step(step);
        ready_idle_en = idle;
        for (int k = 0; k < n_items; k++)
        begin
            // now and then hold off until the block has answered everything
            if (idle && $urandom_range(0, 59) == 0)
                wait_drained();
            pick_item(target, heavy, cmd, pos, val);
            gap = (idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
            issue(cmd, pos, val, gap, 1'b0, NO_TYPED);
        end
    endtask

    // empties the list with deletes near the top, which shift little
    task automatic drain_list(input bit idle);
        int gap;
        int slack;
        while (list_len > 0)
        begin
            slack = (list_len > 4) ? 3 : list_len - 1;
            gap = (idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
            issue(cle_pkg::CMD_DELETE, 9'(list_len - 1 - $urandom_range(0, slack)),
                  rand_word(), gap, 1'b0, NO_TYPED);
        end
    endtask

    task automatic log_mismatch(input string why, input list_result_t want,
                                input list_result_t got);
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
            $display({"%0t: %s: expected rd=%h idx=%h cnt=%0d cap=%0d st=%0d,",
                      " got rd=%h idx=%h cnt=%0d cap=%0d st=%0d"},
                     $realtime, why, want.rd, want.idx, want.cnt, want.cap, want.stat,
                     got.rd, got.idx, got.cnt, got.cap, got.stat);
    endtask

    always @(posedge clk)
    begin : result_check
        list_result_t got;
        list_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.rd = m_tdata[31:0];
            got.idx = m_tdata[40:32];
            got.cnt = m_tdata[49:41];
            got.cap = m_tdata[58:50];
            got.stat = m_tuser;
            if (pending_results.size() == 0)
                log_mismatch("result beat with nothing pending", NO_TYPED, got);
            else
            begin
                want = pending_results.pop_front();
                if (got.rd !== want.rd || got.idx !== want.idx || got.cnt !== want.cnt ||
                    got.cap !== want.cap || got.stat !== want.stat)
                    log_mismatch("result mismatch", want, got);
            end
        end
    end

    // receiver back-pressure in random bursts
    always @(posedge clk)
    begin : ready_gen
        logic rdy_next;
        if (!rst_n || !ready_idle_en)
        begin
            stall_left = 0;
            rdy_next = 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            rdy_next = 1'b0;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(1, 19) - 1;
            rdy_next = 1'b0;
        end
        else
            rdy_next = 1'b1;
        m_tready <= rdy_next;
    end

    initial
    begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        ready_idle_en = 1'b1;

        // directed rows run on the reset growth_step
        for (int i = 0; i < DIR_ROWS; i++)
            issue(DIR_TAB[i].cmd, DIR_TAB[i].pos, DIR_TAB[i].val,
                  $urandom_range(0, 1) ? $urandom_range(1, 19) : 0,
                  DIR_TAB[i].typed, DIR_TAB[i].want);

        run_phase(9'd1, 160, 12, 1'b0, 1'b1);
        run_phase(9'd256, 120, 20, 1'b0, 1'b0);
        run_phase(9'd255, 100, 8, 1'b0, 1'b1);
        run_phase(9'd0, 100, 10, 1'b0, 1'b1);
        // fill to the full store and hover there
        run_phase(9'd64, 500, cle_pkg::DEPTH_DEF, 1'b1, 1'b1);
        drain_list(1'b1);
        // oversized step: the grow runs into the capacity ceiling
        run_phase(9'd511, 240, 140, 1'b1, 1'b1);
        drain_list(1'b1);
        run_phase(9'($urandom_range(1, 256)), 150, 30, 1'b0, 1'b1);
        run_phase(cle_pkg::GS_RESET, 150, 16, 1'b0, 1'b0);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
